>>> rtl/core/hcbm_pkg.sv
// ----------------------------------------------------------------------------
// hcbm_pkg
// Shared types and constants of the handheld console bank mapper.
// ----------------------------------------------------------------------------
package hcbm_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DefMaxRomBanks  = 512;
  localparam int unsigned DefMaxRamBanks  = 16;
  localparam int unsigned DefPhysAddrBits = 24;

  // Field widths
  localparam int unsigned FuncW     = 3;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RomBankW  = 9;
  localparam int unsigned RamBankW  = 4;
  localparam int unsigned PhysW     = 24;
  localparam int unsigned ActionW   = 3;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 56;

  // Operation codes carried in tuser on the input side
  typedef enum logic [FuncW-1:0] {
    FUNC_READ      = 3'd0,
    FUNC_WRITE     = 3'd1,
    FUNC_WORK_BANK = 3'd2,
    FUNC_VID_BANK  = 3'd3,
    FUNC_ROM_BANKS = 3'd4,
    FUNC_RAM_BANK  = 3'd5,
    FUNC_RAM_EN    = 3'd6
  } func_e;

  // Result kinds carried in tuser on the output side
  typedef enum logic [ActionW-1:0] {
    ACT_NONE    = 3'd0,
    ACT_READ    = 3'd1,
    ACT_WRITE   = 3'd2,
    ACT_FORWARD = 3'd3,
    ACT_FF      = 3'd4
  } action_e;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_ROM_BANK_COUNT = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_RAM_BANK_COUNT = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_VIDEO_BASE     = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_WORK_BASE      = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_CART_BASE      = 3'd4;

  // Bus map
  localparam logic [AddrW-1:0] ADDR_IO_START  = 16'hFE00;
  localparam logic [AddrW-1:0] ADDR_VRAM      = 16'h8000;
  localparam logic [AddrW-1:0] ADDR_ROM_HIGH  = 16'h4000;
  localparam logic [AddrW-1:0] ADDR_CART_RAM  = 16'hA000;
  localparam logic [AddrW-1:0] ADDR_WORK_RAM  = 16'hC000;
  localparam logic [2:0]       CART_WIN_TAG   = 3'b101;
  localparam logic [3:0]       WORK_BANK0_TAG = 4'hC;
  localparam logic [3:0]       WORK_ECHO0_TAG = 4'hE;

  // Bank register constants
  localparam logic [ByteW-1:0] SVBK_FIXED   = 8'hF8;
  localparam logic [ByteW-1:0] VBK_FIXED    = 8'hFE;
  localparam logic [3:0]       RAM_EN_KEY   = 4'hA;
  localparam logic [ByteW-1:0] BLOCKED_BYTE = 8'hFF;

  typedef struct packed {
    logic [9:0]          rom_bank_count;
    logic [4:0]          cart_ram_bank_count;
    logic [CfgDataW-1:0] video_ram_base;
    logic [CfgDataW-1:0] work_ram_base;
    logic [CfgDataW-1:0] cart_ram_base;
  } cfg_t;

endpackage

>>> rtl/core/hcbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// hcbm_cfg_regs
// Configuration register file: bank counts and physical base offsets.
// ----------------------------------------------------------------------------
module hcbm_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [hcbm_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [hcbm_pkg::CfgDataW-1:0]   cfg_data_i,
  output hcbm_pkg::cfg_t                  cfg_o
);
  import hcbm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROM_BANK_COUNT: cfg_d.rom_bank_count      = cfg_data_i[9:0];
        CFG_RAM_BANK_COUNT: cfg_d.cart_ram_bank_count = cfg_data_i[4:0];
        CFG_VIDEO_BASE:     cfg_d.video_ram_base      = cfg_data_i;
        CFG_WORK_BASE:      cfg_d.work_ram_base       = cfg_data_i;
        CFG_CART_BASE:      cfg_d.cart_ram_base       = cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_bank_count      <= 10'd2;
      cfg_q.cart_ram_bank_count <= 5'd0;
      cfg_q.video_ram_base      <= '0;
      cfg_q.work_ram_base       <= '0;
      cfg_q.cart_ram_base       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/hcbm_bank_regs.sv
// ----------------------------------------------------------------------------
// hcbm_bank_regs
// Bank select and enable registers, updated by register-write operations.
// ----------------------------------------------------------------------------
module hcbm_bank_regs #(
  parameter int unsigned MAX_ROM_BANKS = hcbm_pkg::DefMaxRomBanks,
  parameter int unsigned MAX_RAM_BANKS = hcbm_pkg::DefMaxRamBanks,
  localparam int unsigned RomSelW = $clog2(MAX_ROM_BANKS),
  localparam int unsigned RamSelW = (MAX_RAM_BANKS > 1) ? $clog2(MAX_RAM_BANKS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  hcbm_pkg::func_e                 func_i,
  input  logic [hcbm_pkg::ByteW-1:0]      data_i,
  input  logic [hcbm_pkg::RomBankW-1:0]   low_rom_bank_i,
  input  logic [hcbm_pkg::RomBankW-1:0]   high_rom_bank_i,
  input  logic [hcbm_pkg::RamBankW-1:0]   ram_bank_select_i,
  input  hcbm_pkg::cfg_t                  cfg_i,
  output logic [RomSelW-1:0]              rom_low_sel_o,
  output logic [RomSelW-1:0]              rom_high_sel_o,
  output logic [RamSelW-1:0]              cart_bank_sel_o,
  output logic [hcbm_pkg::ByteW-1:0]      svbk_o,
  output logic [hcbm_pkg::ByteW-1:0]      vbk_o,
  output logic                            ram_en_o,
  output logic [hcbm_pkg::ByteW-1:0]      svbk_next_o,
  output logic [hcbm_pkg::ByteW-1:0]      vbk_next_o,
  output logic                            ram_en_next_o
);
  import hcbm_pkg::*;

  localparam logic [RomSelW-1:0] RomMaxMask = RomSelW'(MAX_ROM_BANKS - 1);
  localparam logic [RamSelW-1:0] RamMaxMask = RamSelW'(MAX_RAM_BANKS - 1);

  logic [RomSelW-1:0] rom_low_q, rom_low_d, rom_high_q, rom_high_d, rom_mask;
  logic [RamSelW-1:0] cart_sel_q, cart_sel_d, ram_mask;
  logic [9:0]         rom_cnt_m1;
  logic [4:0]         ram_cnt_m1;
  logic [ByteW-1:0]   svbk_q, svbk_d, vbk_q, vbk_d;
  logic               ram_en_q, ram_en_d;

  // count - 1 wraps in the register width, so a zero count masks nothing
  assign rom_cnt_m1 = cfg_i.rom_bank_count - 10'd1;
  assign ram_cnt_m1 = cfg_i.cart_ram_bank_count - 5'd1;
  assign rom_mask   = rom_cnt_m1[RomSelW-1:0] & RomMaxMask;
  assign ram_mask   = ram_cnt_m1[RamSelW-1:0] & RamMaxMask;

  always_comb begin
    rom_low_d  = rom_low_q;
    rom_high_d = rom_high_q;
    cart_sel_d = cart_sel_q;
    svbk_d     = svbk_q;
    vbk_d      = vbk_q;
    ram_en_d   = ram_en_q;
    case (func_i)
      FUNC_WORK_BANK: svbk_d = data_i | SVBK_FIXED;
      FUNC_VID_BANK:  vbk_d  = data_i | VBK_FIXED;
      FUNC_ROM_BANKS: begin
        rom_low_d  = low_rom_bank_i[RomSelW-1:0] & rom_mask;
        rom_high_d = high_rom_bank_i[RomSelW-1:0] & rom_mask;
      end
      FUNC_RAM_BANK:  cart_sel_d = ram_bank_select_i[RamSelW-1:0] & ram_mask;
      FUNC_RAM_EN:    ram_en_d   = (data_i[3:0] == RAM_EN_KEY);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_low_q  <= '0;
      rom_high_q <= RomSelW'(1);
      cart_sel_q <= '0;
      svbk_q     <= SVBK_FIXED;
      vbk_q      <= VBK_FIXED;
      ram_en_q   <= 1'b0;
    end else if (advance_i) begin
      rom_low_q  <= rom_low_d;
      rom_high_q <= rom_high_d;
      cart_sel_q <= cart_sel_d;
      svbk_q     <= svbk_d;
      vbk_q      <= vbk_d;
      ram_en_q   <= ram_en_d;
    end
  end

  assign rom_low_sel_o   = rom_low_q;
  assign rom_high_sel_o  = rom_high_q;
  assign cart_bank_sel_o = cart_sel_q;
  assign svbk_o          = svbk_q;
  assign vbk_o           = vbk_q;
  assign ram_en_o        = ram_en_q;
  assign svbk_next_o     = svbk_d;
  assign vbk_next_o      = vbk_d;
  assign ram_en_next_o   = ram_en_d;

endmodule

>>> rtl/core/hcbm_xlate.sv
// ----------------------------------------------------------------------------
// hcbm_xlate
// Region decode and bus-to-physical address translation for one operation.
// ----------------------------------------------------------------------------
module hcbm_xlate #(
  parameter int unsigned RomSelW        = 9,
  parameter int unsigned RamSelW        = 4,
  parameter int unsigned PHYS_ADDR_BITS = hcbm_pkg::DefPhysAddrBits
) (
  input  hcbm_pkg::func_e                 func_i,
  input  logic [hcbm_pkg::AddrW-1:0]      address_i,
  input  logic [hcbm_pkg::ByteW-1:0]      data_i,
  input  hcbm_pkg::cfg_t                  cfg_i,
  input  logic [RomSelW-1:0]              rom_low_sel_i,
  input  logic [RomSelW-1:0]              rom_high_sel_i,
  input  logic [RamSelW-1:0]              cart_bank_sel_i,
  input  logic [hcbm_pkg::ByteW-1:0]      svbk_i,
  input  logic [hcbm_pkg::ByteW-1:0]      vbk_i,
  input  logic                            ram_en_i,
  output hcbm_pkg::action_e               action_o,
  output logic [hcbm_pkg::PhysW-1:0]      phys_o,
  output logic [hcbm_pkg::ByteW-1:0]      wbyte_o
);
  import hcbm_pkg::*;

  localparam logic [PhysW-1:0] PhysMask = (PHYS_ADDR_BITS >= PhysW) ? {PhysW{1'b1}} :
                                          PhysW'((64'd1 << PHYS_ADDR_BITS) - 64'd1);

  logic [PhysW-1:0] base;
  logic [PhysW:0]   addend, sum;
  logic [2:0]       work_bank;
  logic             cart_win, blocked, blocked_cart, below_io;

  assign cart_win     = (address_i[15:13] == CART_WIN_TAG);
  assign blocked      = !ram_en_i || (cfg_i.cart_ram_bank_count == 5'd0);
  assign blocked_cart = cart_win && blocked;
  assign below_io     = (address_i < ADDR_IO_START);

  // work bank zero selects bank one
  assign work_bank = (svbk_i[2:0] == 3'd0) ? 3'd1 : svbk_i[2:0];

  // pick base and banked window offset; bank * window size is a concatenation
  always_comb begin
    if (address_i < ADDR_ROM_HIGH) begin
      base   = '0;
      addend = (PhysW+1)'({rom_low_sel_i, address_i[13:0]});
    end else if (address_i < ADDR_VRAM) begin
      base   = '0;
      addend = (PhysW+1)'({rom_high_sel_i, address_i[13:0]});
    end else if (address_i < ADDR_CART_RAM) begin
      base   = cfg_i.video_ram_base;
      addend = (PhysW+1)'({vbk_i[0], address_i[12:0]});
    end else if (address_i < ADDR_WORK_RAM) begin
      base   = cfg_i.cart_ram_base;
      addend = (PhysW+1)'({cart_bank_sel_i, address_i[12:0]});
    end else if (address_i[15:12] == WORK_BANK0_TAG ||
                 address_i[15:12] == WORK_ECHO0_TAG) begin
      base   = cfg_i.work_ram_base;
      addend = (PhysW+1)'(address_i[11:0]);
    end else begin
      base   = cfg_i.work_ram_base;
      addend = (PhysW+1)'({work_bank, address_i[11:0]});
    end
  end

  assign sum = {1'b0, base} + addend;

  always_comb begin
    action_o = ACT_NONE;
    phys_o   = '0;
    wbyte_o  = '0;
    case (func_i)
      FUNC_READ: begin
        if (below_io) begin
          if (blocked_cart) begin
            action_o = ACT_FF;
            wbyte_o  = BLOCKED_BYTE;
          end else begin
            action_o = ACT_READ;
            phys_o   = sum[PhysW-1:0] & PhysMask;
          end
        end
      end
      FUNC_WRITE: begin
        if (address_i < ADDR_VRAM) begin
          action_o = ACT_FORWARD;
          phys_o   = PhysW'(address_i);
          wbyte_o  = data_i;
        end else if (below_io && !blocked_cart) begin
          action_o = ACT_WRITE;
          phys_o   = sum[PhysW-1:0] & PhysMask;
          wbyte_o  = data_i;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/handheld_console_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// handheld_console_bank_mapper_core
// Banked memory mapper: bus access translation and bank register handling.
// ----------------------------------------------------------------------------
// One operation per transfer, one per clock cycle sustained while the output
// is not stalled. An operation waits in the input register while the region
// decode and a single 25-bit base-plus-bank add form its result, which is then
// registered in the result register and offered from there; an output stall
// holds both registers. The bank registers update as the operation leaves the
// input register, and the register fields of each result show their values
// after that operation. Configuration writes take effect at once and are meant
// to happen while the mapper is idle; no clearing pass is needed after reset.
module handheld_console_bank_mapper_core #(
  parameter int unsigned MAX_ROM_BANKS  = hcbm_pkg::DefMaxRomBanks,
  parameter int unsigned MAX_RAM_BANKS  = hcbm_pkg::DefMaxRamBanks,
  parameter int unsigned PHYS_ADDR_BITS = hcbm_pkg::DefPhysAddrBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // address[15:0], data_value[23:16], low_rom_bank[32:24], high_rom_bank[41:33],
  // ram_bank_select[45:42], zero[47:46]
  input  logic [hcbm_pkg::InDataW-1:0]     s_axis_tdata,
  // func[2:0]
  input  logic [hcbm_pkg::FuncW-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // phys_offset[23:0], write_byte_out[31:24], work_bank_reg[39:32],
  // video_bank_reg[47:40], cart_ram_on[48], zero[55:49]
  output logic [hcbm_pkg::OutDataW-1:0]    m_axis_tdata,
  // action[2:0]
  output logic [hcbm_pkg::ActionW-1:0]     m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hcbm_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [hcbm_pkg::CfgDataW-1:0]    cfg_data_i
);
  import hcbm_pkg::*;

  localparam int unsigned RomSelW = $clog2(MAX_ROM_BANKS);
  localparam int unsigned RamSelW = (MAX_RAM_BANKS > 1) ? $clog2(MAX_RAM_BANKS) : 1;

  cfg_t               cfg;
  logic               in_valid_q, out_valid_q, advance, in_take;
  logic [InDataW-1:0] in_data_q;
  logic [FuncW-1:0]   in_user_q;
  func_e              func;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  action_e            out_action_q, action;
  logic [PhysW-1:0]   phys;
  logic [ByteW-1:0]   wbyte, svbk, vbk, svbk_next, vbk_next;
  logic               ram_en, ram_en_next;
  logic [RomSelW-1:0] rom_low_sel, rom_high_sel;
  logic [RamSelW-1:0] cart_bank_sel;

  // move the held operation on whenever the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign func          = func_e'(in_user_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
    if (advance) begin
      out_data_q   <= out_data_d;
      out_action_q <= action;
    end
  end

  hcbm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hcbm_bank_regs #(
    .MAX_ROM_BANKS (MAX_ROM_BANKS),
    .MAX_RAM_BANKS (MAX_RAM_BANKS)
  ) u_bank_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .advance_i         (advance),
    .func_i            (func),
    .data_i            (in_data_q[23:16]),
    .low_rom_bank_i    (in_data_q[32:24]),
    .high_rom_bank_i   (in_data_q[41:33]),
    .ram_bank_select_i (in_data_q[45:42]),
    .cfg_i             (cfg),
    .rom_low_sel_o     (rom_low_sel),
    .rom_high_sel_o    (rom_high_sel),
    .cart_bank_sel_o   (cart_bank_sel),
    .svbk_o            (svbk),
    .vbk_o             (vbk),
    .ram_en_o          (ram_en),
    .svbk_next_o       (svbk_next),
    .vbk_next_o        (vbk_next),
    .ram_en_next_o     (ram_en_next)
  );

  hcbm_xlate #(
    .RomSelW        (RomSelW),
    .RamSelW        (RamSelW),
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_xlate (
    .func_i          (func),
    .address_i       (in_data_q[15:0]),
    .data_i          (in_data_q[23:16]),
    .cfg_i           (cfg),
    .rom_low_sel_i   (rom_low_sel),
    .rom_high_sel_i  (rom_high_sel),
    .cart_bank_sel_i (cart_bank_sel),
    .svbk_i          (svbk),
    .vbk_i           (vbk),
    .ram_en_i        (ram_en),
    .action_o        (action),
    .phys_o          (phys),
    .wbyte_o         (wbyte)
  );

  assign out_data_d = {7'd0, ram_en_next, vbk_next, svbk_next, wbyte, phys};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_action_q;

endmodule

>>> sim/handheld_console_bank_mapper_core_tb.sv
// ----------------------------------------------------------------------------
// handheld_console_bank_mapper_core_tb
// Drives bus accesses and bank register operations into the mapper under
// several register settings. A local model of the banking state predicts the
// action, offset, byte and register fields of each result; each result is
// checked in order against it. Both streams stall at random in all runs but one.
// ----------------------------------------------------------------------------
module handheld_console_bank_mapper_core_tb;
  import hcbm_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned IdlePercent = 34;
  localparam logic [FuncW-1:0] FUNC_NOP = 3'd7;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [AddrW-1:0]    addr;
    logic [ByteW-1:0]    data;
    logic [RomBankW-1:0] low_bank;
    logic [RomBankW-1:0] high_bank;
    logic [RamBankW-1:0] ram_bank;
  } bus_op_t;

  typedef struct packed {
    action_e          action;
    logic [PhysW-1:0] phys;
    logic [ByteW-1:0] wbyte;
    logic [ByteW-1:0] svbk;
    logic [ByteW-1:0] vbk;
    logic             ram_on;
  } map_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic [FuncW-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [ActionW-1:0]   m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // Predicted register settings and banking state
  logic [9:0]          rom_count_q = 10'd2;
  logic [4:0]          ram_count_q = 5'd0;
  logic [PhysW-1:0]    video_base_q = '0;
  logic [PhysW-1:0]    work_base_q = '0;
  logic [PhysW-1:0]    cart_base_q = '0;
  logic [RomBankW-1:0] rom_low_q = 9'd0;
  logic [RomBankW-1:0] rom_high_q = 9'd1;
  logic [RamBankW-1:0] cart_sel_q = 4'd0;
  logic [ByteW-1:0]    svbk_q = SVBK_FIXED;
  logic [ByteW-1:0]    vbk_q = VBK_FIXED;
  logic                ram_en_q = 1'b0;

  map_result_t pending_results[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;

  handheld_console_bank_mapper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [PhysW-1:0] translate_addr(logic [AddrW-1:0] a);
    int unsigned sum;
    int unsigned wbank;
    wbank = (svbk_q[2:0] == 3'd0) ? 1 : svbk_q[2:0];
    if (a < ADDR_ROM_HIGH) begin
      sum = rom_low_q * 32'h4000 + a[13:0];
    end else if (a < ADDR_VRAM) begin
      sum = rom_high_q * 32'h4000 + a[13:0];
    end else if (a < ADDR_CART_RAM) begin
      sum = video_base_q + vbk_q[0] * 32'h2000 + a[12:0];
    end else if (a < ADDR_WORK_RAM) begin
      sum = cart_base_q + cart_sel_q * 32'h2000 + a[12:0];
    end else if (a[15:12] == WORK_BANK0_TAG || a[15:12] == WORK_ECHO0_TAG) begin
      sum = work_base_q + a[11:0];
    end else begin
      sum = work_base_q + wbank * 32'h1000 + a[11:0];
    end
    return sum[PhysW-1:0];
  endfunction

  // Apply one operation to the banking state and form its result
  function automatic map_result_t map_operation(bus_op_t op);
    map_result_t res;
    logic        blocked;
    logic        cart;
    logic [9:0]  rom_mask;
    logic [4:0]  ram_mask;
    res = '0;
    res.action = ACT_NONE;
    blocked = !ram_en_q || ram_count_q == 5'd0;
    cart = op.addr[15:13] == CART_WIN_TAG;
    case (op.func)
      FUNC_READ: begin
        if (op.addr < ADDR_IO_START) begin
          if (cart && blocked) begin
            res.action = ACT_FF;
            res.wbyte = BLOCKED_BYTE;
          end else begin
            res.action = ACT_READ;
            res.phys = translate_addr(op.addr);
          end
        end
      end
      FUNC_WRITE: begin
        if (op.addr < ADDR_VRAM) begin
          res.action = ACT_FORWARD;
          res.phys = {8'h00, op.addr};
          res.wbyte = op.data;
        end else if (op.addr < ADDR_IO_START && !(cart && blocked)) begin
          res.action = ACT_WRITE;
          res.phys = translate_addr(op.addr);
          res.wbyte = op.data;
        end
      end
      FUNC_WORK_BANK: svbk_q = op.data | SVBK_FIXED;
      FUNC_VID_BANK: vbk_q = op.data | VBK_FIXED;
      FUNC_ROM_BANKS: begin
        rom_mask = rom_count_q - 10'd1;
        rom_low_q = op.low_bank & rom_mask[8:0];
        rom_high_q = op.high_bank & rom_mask[8:0];
      end
      FUNC_RAM_BANK: begin
        ram_mask = ram_count_q - 5'd1;
        cart_sel_q = op.ram_bank & ram_mask[3:0];
      end
      FUNC_RAM_EN: ram_en_q = op.data[3:0] == RAM_EN_KEY;
      default: ;
    endcase
    res.svbk = svbk_q;
    res.vbk = vbk_q;
    res.ram_on = ram_en_q;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Hold valid high across back-to-back transfers; drop it only for a gap
  task automatic send_op(bus_op_t op);
    while (src_idle_en && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, op.ram_bank, op.high_bank, op.low_bank, op.data, op.addr};
    s_axis_tuser <= op.func;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(map_operation(op));
  endtask

  task automatic do_op(logic [FuncW-1:0] func, logic [AddrW-1:0] addr,
                       logic [ByteW-1:0] data = 8'h00,
                       logic [RomBankW-1:0] low_bank = '0,
                       logic [RomBankW-1:0] high_bank = '0,
                       logic [RamBankW-1:0] ram_bank = '0);
    bus_op_t op;
    op = '{func, addr, data, low_bank, high_bank, ram_bank};
    send_op(op);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROM_BANK_COUNT: rom_count_q = val[9:0];
      CFG_RAM_BANK_COUNT: ram_count_q = val[4:0];
      CFG_VIDEO_BASE: video_base_q = val;
      CFG_WORK_BASE: work_base_q = val;
      CFG_CART_BASE: cart_base_q = val;
      default: ;
    endcase
  endtask

  // Only call with the mapper idle
  task automatic configure(logic [9:0] rom_cnt, logic [4:0] ram_cnt,
                           logic [PhysW-1:0] vbase, logic [PhysW-1:0] wbase,
                           logic [PhysW-1:0] cbase);
    write_reg(CFG_ROM_BANK_COUNT, {14'h0, rom_cnt});
    write_reg(CFG_RAM_BANK_COUNT, {19'h0, ram_cnt});
    write_reg(CFG_VIDEO_BASE, vbase);
    write_reg(CFG_WORK_BASE, wbase);
    write_reg(CFG_CART_BASE, cbase);
    cfg_valid_i <= 1'b0;
  endtask

  // Window edges under reset settings, blocked cartridge RAM, I/O area, no-op
  task automatic test_reset_map();
    do_op(FUNC_READ, 16'h0000);
    do_op(FUNC_READ, 16'h7FFF);
    do_op(FUNC_READ, 16'h9FFF);
    do_op(FUNC_READ, 16'hA000);
    do_op(FUNC_WRITE, 16'hBFFF, 8'h5A);
    do_op(FUNC_READ, 16'hCFFF);
    do_op(FUNC_READ, 16'hD000);
    do_op(FUNC_READ, 16'hEFFF);
    do_op(FUNC_WRITE, 16'hFDFF, 8'hA5);
    do_op(FUNC_READ, 16'hFE00);
    do_op(FUNC_WRITE, 16'hFFFF, 8'hFF);
    do_op(FUNC_WRITE, 16'h7FFF, 8'hC3);
    do_op(FUNC_NOP, 16'hFFFF, 8'hFF, 9'h1FF, 9'h1FF, 4'hF);
    wait_results_drained();
  endtask

  // Largest banks and bases, so offsets wrap at the physical width
  task automatic test_extreme_settings();
    configure(10'd512, 5'd16, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    do_op(FUNC_RAM_EN, 16'h0000, 8'hFA);
    do_op(FUNC_ROM_BANKS, 16'h0000, 8'h00, 9'h1FF, 9'h1FF);
    do_op(FUNC_RAM_BANK, 16'h0000, 8'h00, 9'h000, 9'h000, 4'hF);
    do_op(FUNC_WORK_BANK, 16'h0000, 8'h07);
    do_op(FUNC_VID_BANK, 16'h0000, 8'h01);
    do_op(FUNC_READ, 16'h3FFF);
    do_op(FUNC_READ, 16'h4000);
    do_op(FUNC_WRITE, 16'h8000, 8'h81);
    do_op(FUNC_READ, 16'hB123);
    do_op(FUNC_WRITE, 16'hF000, 8'h0F);
    do_op(FUNC_RAM_EN, 16'h0000, 8'h0B);
    wait_results_drained();
  endtask

  // Zero and non-power-of-two bank counts
  task automatic test_count_masks();
    configure(10'd0, 5'd31, 24'h123456, 24'h654321, 24'hABCDEF);
    do_op(FUNC_ROM_BANKS, 16'h0000, 8'h00, 9'h1FF, 9'h155);
    do_op(FUNC_READ, 16'h0001);
    do_op(FUNC_RAM_EN, 16'h0000, 8'h0A);
    do_op(FUNC_RAM_BANK, 16'h0000, 8'h00, 9'h000, 9'h000, 4'hF);
    do_op(FUNC_READ, 16'hA001);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int unsigned count, bit idle);
    bus_op_t     op;
    int unsigned pick;
    src_idle_en = idle;
    sink_idle_en = idle;
    repeat (count) begin
      op.addr = $urandom;
      op.data = $urandom;
      op.low_bank = $urandom;
      op.high_bank = $urandom;
      op.ram_bank = $urandom;
      pick = $urandom_range(99);
      if (pick < 38) op.func = FUNC_READ;
      else if (pick < 62) op.func = FUNC_WRITE;
      else if (pick < 70) op.func = FUNC_WORK_BANK;
      else if (pick < 76) op.func = FUNC_VID_BANK;
      else if (pick < 84) op.func = FUNC_ROM_BANKS;
      else if (pick < 90) op.func = FUNC_RAM_BANK;
      else op.func = FUNC_RAM_EN;
      // Mostly enable cartridge RAM so its window is reached
      if (op.func == FUNC_RAM_EN && $urandom_range(3) != 0) op.data[3:0] = RAM_EN_KEY;
      send_op(op);
    end
    wait_results_drained();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  always @(posedge clk_i) begin : result_check
    map_result_t got;
    map_result_t want;
    m_axis_tready <= !sink_idle_en || $urandom_range(99) >= IdlePercent;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action = action_e'(m_axis_tuser);
      got.phys = m_axis_tdata[23:0];
      got.wbyte = m_axis_tdata[31:24];
      got.svbk = m_axis_tdata[39:32];
      got.vbk = m_axis_tdata[47:40];
      got.ram_on = m_axis_tdata[48];
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("action", want.action, got.action);
        check_field("phys_offset", want.phys, got.phys);
        check_field("write_byte_out", want.wbyte, got.wbyte);
        check_field("work_bank_reg", want.svbk, got.svbk);
        check_field("video_bank_reg", want.vbk, got.vbk);
        check_field("cart_ram_on", want.ram_on, got.ram_on);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_map();
    test_extreme_settings();
    test_count_masks();
    configure(10'd2, 5'd1, 24'h000000, 24'h000000, 24'h000000);
    test_random_traffic(250, 1'b1);
    configure(10'd512, 5'd16, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    test_random_traffic(250, 1'b1);
    configure(10'(1 << $urandom_range(1, 9)), 5'(1 << $urandom_range(0, 4)),
              24'($urandom), 24'($urandom), 24'($urandom));
    test_random_traffic(300, 1'b0);
    configure(10'($urandom_range(0, 1023)), 5'($urandom_range(0, 31)),
              24'($urandom), 24'($urandom), 24'($urandom));
    test_random_traffic(250, 1'b1);
    configure(10'(1 << $urandom_range(1, 9)),
              ($urandom_range(3) == 0) ? 5'd0 : 5'(1 << $urandom_range(0, 4)),
              24'($urandom), 24'($urandom), 24'($urandom));
    test_random_traffic(450, 1'b1);
    wait_results_drained();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
